// ===== src/rei_pkg.sv =====
// ----------------------------------------------------------------------------
// rei_pkg
// Shared types and constants for the rotary encoder interface.
// ----------------------------------------------------------------------------
package rei_pkg;

   localparam int unsigned FsWidth    = 32;
   localparam int unsigned CprWidth   = 16;
   localparam int unsigned RevWidth   = 32;
   localparam int unsigned EventWidth = 32;
   localparam int unsigned VelWidth   = 16;
   localparam int unsigned DebWidth   = 3;
   localparam int unsigned DivSteps   = 32;
   localparam int unsigned DivCntWidth = $clog2(DivSteps);

   localparam logic [DebWidth-1:0] DebMin = DebWidth'(1);
   localparam logic [DebWidth-1:0] DebMax = DebWidth'(5);

   typedef enum logic [1:0] {
      MODE_PIN = 2'd0,
      MODE_VEL = 2'd1,
      MODE_SW  = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_FS_VELOCITY = 1'b0,
      CSR_MAX_CPR     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DivSteps-1:0]   dividend;
      logic [CprWidth-1:0]   divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                  done;
      logic [DivSteps-1:0]   quotient;
   } div_status_type;

endpackage

// ===== src/rei_divider.sv =====
// ----------------------------------------------------------------------------
// rei_divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
module rei_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  rei_pkg::div_ctrl_type   ctrl,
   output rei_pkg::div_status_type status
);
   import rei_pkg::*;

   logic [CprWidth-1:0]    rem_ff, rem_in;
   logic [DivSteps-1:0]    quo_ff, quo_in;
   logic [CprWidth-1:0]    div_ff, div_in;
   logic [DivCntWidth-1:0] count_ff, count_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CprWidth:0]      rem_shift;
   logic [CprWidth:0]      rem_diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DivSteps-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (ctrl.start) begin
         rem_in   = '0;
         quo_in   = ctrl.dividend;
         div_in   = ctrl.divisor;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         // trial subtract; keep the difference when it does not go negative
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_diff[CprWidth-1:0];
            quo_in = {quo_ff[DivSteps-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CprWidth-1:0];
            quo_in = {quo_ff[DivSteps-2:0], 1'b0};
         end
         count_in = count_ff + DivCntWidth'(1);
         if (count_ff == DivCntWidth'(DivSteps - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ===== src/rotary_encoder_interface.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_interface
// Quadrature position counter with velocity read and push-switch debounce.
// ----------------------------------------------------------------------------
// Each request transaction carries a mode in req_tuser and the A, B and switch
// pin levels in req_tdata, and yields exactly one response transaction with
// direction, position, revolutions, velocity and switch state. Pin samples,
// switch polls, mode-three reports and velocity reads with no edges counted
// finish in the accept cycle and show on rsp_tvalid in the cycle after. A
// velocity read with a nonzero edge count steps through ST_MUL for the 32x32
// multiply, ST_START to launch the divider, ST_DIV while the bit-per-cycle
// restoring divider runs until its done flag, and ST_RESP to load the
// response register. The block accepts no request while that runs. The
// response register lets a new request enter in the same cycle in which a
// pending response is taken. Configuration writes on csr_ are always ready.
// ----------------------------------------------------------------------------
module rotary_encoder_interface (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = mode[1:0]; tdata = pin_a, pin_b, pin_sw, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [7:0]  req_tdata,
   // response: tdata = direction, position[15:0], revolutions[31:0],
   //           velocity[15:0], switch_released, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import rei_pkg::*;

   // configuration registers
   logic [FsWidth-1:0]  fs_velocity_ff, fs_velocity_in;
   logic [CprWidth-1:0] max_cpr_ff, max_cpr_in;

   // encoder state
   logic                  prev_b_ff, prev_b_in;
   logic                  dir_ff, dir_in;
   logic [CprWidth-1:0]   pos_ff, pos_in;
   logic [RevWidth-1:0]   rev_ff, rev_in;
   logic [EventWidth-1:0] event_ff, event_in;
   logic [DebWidth-1:0]   deb_ff, deb_in;
   logic [DivSteps-1:0]   prod_ff, prod_in;

   // sequencer
   state_type state_ff, state_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [71:0]         rsp_data_ff, rsp_data_in;

   // control
   logic           accept;
   logic           rsp_space;
   logic           slow_read;
   logic           load_now;
   logic           load_div;
   mode_type       mode;
   logic           pin_a, pin_b, pin_sw;
   logic [VelWidth-1:0] imm_vel;
   logic           imm_rel;
   logic [CprWidth-1:0] pos_inc;
   logic [DebWidth-1:0] deb_inc;
   logic [DivSteps-1:0] mul_full;

   div_ctrl_type   div_ctrl;
   div_status_type div_status;

   assign mode   = mode_type'(req_tuser);
   assign pin_a  = req_tdata[0];
   assign pin_b  = req_tdata[1];
   assign pin_sw = req_tdata[2];

   assign csr_ready = 1'b1;
   assign rsp_space = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   // only a read with edges pending needs the divider
   assign slow_read = (mode == MODE_VEL) && (event_ff != '0);

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && slow_read) state_in = ST_MUL;
         ST_MUL:   state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_status.done) state_in = ST_RESP;
         ST_RESP:  if (rsp_space) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---- sequencer outputs ----
   always_comb begin
      req_tready        = 1'b0;
      load_now          = 1'b0;
      load_div          = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = prod_ff;
      div_ctrl.divisor  = max_cpr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = rsp_space;
            load_now   = accept && !slow_read;
         end
         ST_START: div_ctrl.start = 1'b1;
         ST_RESP:  load_div = rsp_space;
         default: ;
      endcase
   end

   rei_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_status)
   );

   // ---- datapath ----
   always_comb begin
      fs_velocity_in = fs_velocity_ff;
      max_cpr_in     = max_cpr_ff;
      prev_b_in      = prev_b_ff;
      dir_in         = dir_ff;
      pos_in         = pos_ff;
      rev_in         = rev_ff;
      event_in       = event_ff;
      deb_in         = deb_ff;
      prod_in        = prod_ff;
      imm_vel        = '0;
      imm_rel        = 1'b1;
      pos_inc        = pos_ff + CprWidth'(1);
      deb_inc        = deb_ff + DebWidth'(1);
      // low word of the product only; it wraps at 32 bits
      mul_full       = event_ff * fs_velocity_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FS_VELOCITY: fs_velocity_in = csr_data;
            CSR_MAX_CPR:     max_cpr_in     = csr_data[CprWidth-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         unique case (mode)
            MODE_PIN: begin
               // advance on a rising edge of B, latch A as direction
               if (pin_b && !prev_b_ff) begin
                  dir_in   = pin_a;
                  event_in = event_ff + EventWidth'(1);
                  if (pos_inc >= max_cpr_ff) begin
                     pos_in = '0;
                     rev_in = rev_ff + RevWidth'(1);
                  end else begin
                     pos_in = pos_inc;
                  end
               end
               prev_b_in = pin_b;
            end
            MODE_SW: begin
               if (!pin_sw) begin
                  if (deb_inc > DebMax) begin
                     deb_in  = DebMax;
                     imm_rel = 1'b0;
                  end else begin
                     deb_in = deb_inc;
                  end
               end else if (deb_ff <= DebMin) begin
                  deb_in = DebMin;
               end else begin
                  deb_in = deb_ff - DebWidth'(1);
               end
            end
            MODE_VEL, MODE_NOP: ;
            default: ;
         endcase
      end

      // take the product, then drop the edge count
      if (state_ff == ST_MUL) begin
         prod_in  = mul_full;
         event_in = '0;
      end
   end

   // ---- response register ----
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_now) begin
         rsp_data_in  = {6'b0, imm_rel, imm_vel, rev_in, pos_in, dir_in};
         rsp_valid_in = 1'b1;
      end else if (load_div) begin
         rsp_data_in  = {6'b0, 1'b1, div_status.quotient[VelWidth-1:0],
                         rev_ff, pos_ff, dir_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_velocity_ff <= FsWidth'(1);
         max_cpr_ff     <= CprWidth'(24);
         prev_b_ff      <= 1'b1;
         dir_ff         <= 1'b0;
         pos_ff         <= '0;
         rev_ff         <= '0;
         event_ff       <= '0;
         deb_ff         <= DebMin;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fs_velocity_ff <= fs_velocity_in;
         max_cpr_ff     <= max_cpr_in;
         prev_b_ff      <= prev_b_in;
         dir_ff         <= dir_in;
         pos_ff         <= pos_in;
         rev_ff         <= rev_in;
         event_ff       <= event_in;
         deb_ff         <= deb_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions ----
   // hold the debounce counter inside its saturating range
   a_deb_range: assert property (@(posedge clock) disable iff (reset)
      (deb_ff >= DebMin) && (deb_ff <= DebMax))
      else $error("debounce level out of range");

   // divider completes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider done outside wait state");

   // edge count is cleared once the product has been taken
   a_event_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (event_ff == '0))
      else $error("edge count not cleared by velocity read");

   // never load a new response over one still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(load_now || load_div))
      else $error("response overwritten");

endmodule

// ===== dv/rotary_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_checker
// Watches the request, response and register channels, keeps its own model
// of the encoder counters and compares every response transaction with the
// oldest prediction.
// ----------------------------------------------------------------------------
module rotary_encoder_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [7:0]        req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [71:0]       rsp_tdata,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   output int unsigned       failures,
   output int unsigned       outstanding,
   output int unsigned       readings_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import rei_pkg::*;

   typedef struct {
      logic        dir;
      logic [15:0] pos;
      logic [31:0] rev;
      logic [15:0] vel;
      logic        released;
   } encoder_reading_type;

   logic [31:0]         fs_scale;
   logic [15:0]         cpr;
   logic                last_b;
   logic                dir_q;
   logic [15:0]         pos_q;
   logic [31:0]         rev_q;
   logic [31:0]         edge_count;
   logic [2:0]          deb_q;
   encoder_reading_type expected_readings[$];

   // Advance the counter model by one request and return the reading it gives.
   function automatic encoder_reading_type step_encoder(mode_type mode, logic a, logic b,
                                                        logic sw);
      encoder_reading_type r;
      logic [31:0]         product;
      r.vel      = '0;
      r.released = 1'b1;
      case (mode)
         MODE_PIN: begin
            if (b && !last_b) begin
               dir_q      = a;
               edge_count = edge_count + 32'd1;
               pos_q      = pos_q + 16'd1;
               if (pos_q >= cpr) begin
                  pos_q = '0;
                  rev_q = rev_q + 32'd1;
               end
            end
            last_b = b;
         end
         MODE_VEL: begin
            if (edge_count != 0) begin
               product    = edge_count * fs_scale;
               // a zero divisor answers all ones, as the divider does
               r.vel      = (cpr == 0) ? 16'hFFFF : 16'(product / 32'(cpr));
               edge_count = '0;
            end
         end
         MODE_SW: begin
            if (!sw) begin
               if (deb_q >= DebMax) r.released = 1'b0;
               else deb_q = deb_q + 3'd1;
            end else if (deb_q > DebMin) begin
               deb_q = deb_q - 3'd1;
            end
         end
         default: ;
      endcase
      r.dir = dir_q;
      r.pos = pos_q;
      r.rev = rev_q;
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   initial begin
      failures      = 0;
      outstanding   = 0;
      readings_seen = 0;
   end

   always @(posedge clock) begin
      encoder_reading_type want;
      if (reset) begin
         fs_scale   = 32'd1;
         cpr        = 16'd24;
         last_b     = 1'b1;
         dir_q      = 1'b0;
         pos_q      = '0;
         rev_q      = '0;
         edge_count = '0;
         deb_q      = DebMin;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FS_VELOCITY: fs_scale = csr_data;
               CSR_MAX_CPR:     cpr      = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
               failures++;
               $display("%0t ns: response with nothing expected, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               check_field("direction", 32'(want.dir), 32'(rsp_tdata[0]));
               check_field("position", 32'(want.pos), 32'(rsp_tdata[16:1]));
               check_field("revolutions", want.rev, rsp_tdata[48:17]);
               check_field("velocity", 32'(want.vel), 32'(rsp_tdata[64:49]));
               check_field("switch_released", 32'(want.released), 32'(rsp_tdata[65]));
               check_field("zero fill", 32'd0, 32'(rsp_tdata[71:66]));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(step_encoder(mode_type'(req_tuser), req_tdata[0],
                                                     req_tdata[1], req_tdata[2]));
         end
      end
      outstanding = expected_readings.size();
   end

endmodule

// ===== dv/rotary_encoder_interface_test.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_interface_test
// Drives pin samples, velocity reads and switch polls into the encoder block
// under random flow control on both streams, sweeps the scale and wrap
// registers through several settings and lets the checker score responses.
// ----------------------------------------------------------------------------
module rotary_encoder_interface_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rei_pkg::*;

   localparam int unsigned IdleLimit   = 3000;  // cycles with no transaction at all
   localparam int unsigned StallCycles = 300;   // long response hold-off
   localparam int unsigned SettleDelay = 40;    // longer than a velocity read
   localparam int unsigned PhaseItems  = 105;
   localparam int unsigned PhaseCount  = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // mode[1:0]
   logic [7:0]  req_tdata;   // pin_a, pin_b, pin_sw, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // direction, position, revolutions, velocity,
                             // switch_released, zero fill
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned readings_seen;

   // shared flow-control knobs for the two driver processes, and run counters
   bit          no_idle;
   bit          stall_request;
   int unsigned requests_sent;
   int unsigned settings_used;
   int unsigned idle_cycles;

   rotary_encoder_interface u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rotary_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .failures      (failures),
      .outstanding   (outstanding),
      .readings_seen (readings_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run when no transaction of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Watchdog expired after %0d quiet cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request transaction; return at the falling edge after acceptance
   // with tvalid still high, so a back-to-back request only swaps the payload.
   task automatic send_request(mode_type mode, logic a, logic b, logic sw);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'b0, sw, b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      requests_sent++;
   endtask

   // Drop the request valid, wait until every response is in, then let the
   // block settle before anything touches the registers.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SettleDelay) @(negedge clock);
   endtask

   // Write both registers back to back; hold valid across the pair.
   task automatic set_scaling(logic [31:0] fs, logic [15:0] max_cpr);
      csr_valid <= 1'b1;
      csr_index <= CSR_FS_VELOCITY;
      csr_data  <= fs;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_MAX_CPR;
      csr_data  <= 32'(max_cpr);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Response side: random ready gaps, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         int unsigned gap;
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (StallCycles) @(negedge clock);
            stall_request = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 17);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      logic        last_b;
      logic        b;
      logic        sw;
      logic        switch_held;
      int unsigned pick;
      logic [31:0] fs;
      logic [15:0] max_cpr;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_index     = 1'b0;
      csr_data      = '0;
      no_idle       = 1'b0;
      stall_request = 1'b0;
      requests_sent = 0;
      settings_used = 1;
      idle_cycles   = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset register values.
      // Mode three only reports state; velocity read with no edges gives 0.
      send_request(MODE_NOP, 1'b1, 1'b1, 1'b1);
      send_request(MODE_VEL, 1'b0, 1'b0, 1'b0);
      // B high right after reset is no edge: the previous B resets high.
      send_request(MODE_PIN, 1'b1, 1'b1, 1'b1);
      send_request(MODE_PIN, 1'b1, 1'b0, 1'b0);
      send_request(MODE_PIN, 1'b1, 1'b1, 1'b0);   // backward edge
      send_request(MODE_PIN, 1'b0, 1'b1, 1'b1);   // B held high, no edge
      send_request(MODE_PIN, 1'b0, 1'b0, 1'b1);
      send_request(MODE_PIN, 1'b0, 1'b1, 1'b0);   // forward edge
      send_request(MODE_VEL, 1'b1, 1'b1, 1'b1);
      // Press long enough to saturate the debounce, then release to the floor.
      repeat (6) send_request(MODE_SW, 1'b1, 1'b1, 1'b0);
      repeat (5) send_request(MODE_SW, 1'b0, 1'b0, 1'b1);

      // Full-scale factor with one edge per revolution: every edge wraps.
      drain_responses();
      set_scaling(32'hFFFF_FFFF, 16'd1);
      repeat (3) begin
         send_request(MODE_PIN, 1'b1, 1'b0, 1'b0);
         send_request(MODE_PIN, 1'b0, 1'b1, 1'b1);
      end
      send_request(MODE_VEL, 1'b0, 1'b0, 1'b0);

      // Random part: mostly edge-rich pin streams under changing settings.
      last_b      = 1'b1;
      switch_held = 1'b0;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0:       begin fs = 32'd0;            max_cpr = 16'hFFFF;                  end
            1:       begin fs = 32'hFFFF_FFFF;    max_cpr = 16'd1;                     end
            2:       begin fs = $urandom;         max_cpr = 16'd0;                     end
            3:       begin fs = 32'd1;            max_cpr = 16'd24;                    end
            6:       begin fs = $urandom;         max_cpr = 16'($urandom_range(1, 65535)); end
            default: begin fs = $urandom;         max_cpr = 16'($urandom_range(1, 12)); end
         endcase
         drain_responses();
         set_scaling(fs, max_cpr);
         // hold the response side off for a long stretch in one phase
         if (phase == 3) stall_request = 1'b1;
         for (int n = 0; n < PhaseItems; n++) begin
            no_idle = ((n / 35) % 3) == 1;
            pick    = $urandom_range(0, 99);
            if (pick < 65) begin
               b      = ($urandom_range(0, 9) < 7) ? ~last_b : last_b;
               last_b = b;
               send_request(MODE_PIN, 1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
            end else if (pick < 77) begin
               send_request(MODE_VEL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
               if ($urandom_range(0, 5) == 0) switch_held = ~switch_held;
               // mostly steady level with an occasional bounce
               sw = switch_held ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
               send_request(MODE_SW, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sw);
            end else begin
               send_request(MODE_NOP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
         end
      end
      no_idle = 1'b0;

      drain_responses();
      $display("Covered %0d requests and %0d responses over %0d register settings,",
               requests_sent, readings_seen, settings_used);
      $display("including zero and one divisors, full-scale factor and a long response stall.");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found", failures);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rei_pkg.sv
src/rei_divider.sv
src/rotary_encoder_interface.sv
dv/rotary_encoder_checker.sv
dv/rotary_encoder_interface_test.sv
